[src/soft_knee_peak_limiter_macros.svh]
// Assertion macros shared by the limiter RTL.
`ifndef SOFT_KNEE_PEAK_LIMITER_MACROS_SVH
`define SOFT_KNEE_PEAK_LIMITER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SKPL_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define SKPL_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/skpl_pkg.sv]
// Types, constants and helper functions of the soft-knee peak limiter.
package skpl_pkg;

	localparam int CHANNELS = 8;
	localparam int CH_W = $clog2(CHANNELS);
	localparam int MUL_W = 33;
	localparam int PROD_W = 2 * MUL_W;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 23;
	localparam int DIV_NUM_W = 29;
	localparam int DIV_DEN_W = 16;
	localparam int DIV_Q_W = 13;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KNEE      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ATTACK    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SHARED    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_ACT       = 3'd6;

	// Register reset values.
	localparam logic signed [15:0] THR_RST = -16'sd256;
	localparam logic [12:0] KNEE_RST = 13'd1536;
	localparam logic [15:0] ATK_RST = 16'd62604;
	localparam logic [15:0] REL_RST = 16'd65505;
	localparam logic [19:0] HOLD_RST = 20'd4800;
	localparam logic [22:0] ACT_RST = 23'd16;

	// Scale factors: 1/256 dB per log2 unit, and log2 units per dB.
	localparam logic [MUL_W-1:0] K_DB_PER_LOG2 = 33'd394566;
	localparam logic [MUL_W-1:0] K_LOG2_PER_DB = 33'd174165;
	localparam logic signed [15:0] GAIN_MIN = -16'sd24576;
	localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

	typedef enum logic [3:0] {
		S_IDLE, S_LOG, S_LVL, S_LVL2, S_KSQ, S_KDIV0, S_KDIV,
		S_SM1, S_SM2, S_SM3, S_NS, S_N, S_LIN, S_APP, S_OUT
	} skpl_state_t;

	// Integer square root, bit by bit, for elaboration-time tables.
	function automatic logic [63:0] isqrt_c(input logic [63:0] v_in);
		logic [63:0] v;
		logic [63:0] r;
		logic [63:0] b;
		v = v_in;
		r = '0;
		for (int i = 0; i < 32; i++) begin
			b = 64'd1 << (62 - 2 * i);
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
		end
		return r;
	endfunction

	// 2^(-2^-k) in Q30, by a chain of square roots from 2^(-1/2).
	function automatic logic [30:0] root_q30(input int k);
		logic [63:0] f;
		f = isqrt_c(64'd1 << 59);
		for (int j = 1; j < k; j++) begin
			f = isqrt_c(f << 30);
		end
		return f[30:0];
	endfunction

	localparam logic [30:0] ROOT_TBL [16] = '{
		root_q30(1), root_q30(2), root_q30(3), root_q30(4),
		root_q30(5), root_q30(6), root_q30(7), root_q30(8),
		root_q30(9), root_q30(10), root_q30(11), root_q30(12),
		root_q30(13), root_q30(14), root_q30(15), root_q30(16)
	};

	// Limit a gain to the range from GAIN_MIN to 0 dB.
	function automatic logic signed [15:0] gain_clamp(input logic signed [19:0] v);
		logic signed [15:0] g;
		if (v > 20'sd0) begin
			g = 16'sd0;
		end else if (v < 20'(GAIN_MIN)) begin
			g = GAIN_MIN;
		end else begin
			g = v[15:0];
		end
		return g;
	endfunction

endpackage

[src/skpl_if.sv]
// Valid/ready channel interfaces for limiter input and result beats.
interface skpl_in_if;
	logic valid;
	logic ready;
	logic signed [23:0] in_sample;
	logic signed [23:0] sidechain_sample;
	logic use_sidechain;
	logic [2:0] channel;

	modport source(output valid, in_sample, sidechain_sample, use_sidechain, channel,
		input ready);
	modport sink(input valid, in_sample, sidechain_sample, use_sidechain, channel,
		output ready);
endinterface

interface skpl_out_if;
	logic valid;
	logic ready;
	logic signed [23:0] out_sample;
	logic signed [15:0] gain_db;
	logic limiter_active;

	modport source(output valid, out_sample, gain_db, limiter_active, input ready);
	modport sink(input valid, out_sample, gain_db, limiter_active, output ready);
endinterface

[src/skpl_mul.sv]
// Shared signed multiplier with a registered product.
module skpl_mul (
	input  logic clk,
	input  logic signed [skpl_pkg::MUL_W-1:0] a,
	input  logic signed [skpl_pkg::MUL_W-1:0] b,
	output logic signed [skpl_pkg::PROD_W-1:0] p
);

	logic signed [skpl_pkg::PROD_W-1:0] p_q;

	// One product per cycle, ready the cycle after the operands.
	always_ff @(posedge clk) begin
		p_q <= skpl_pkg::PROD_W'(a) * skpl_pkg::PROD_W'(b);
	end

	assign p = p_q;

endmodule

[src/skpl_div.sv]
// Restoring divider for the knee curve, one quotient bit per cycle.
module skpl_div (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [skpl_pkg::DIV_NUM_W-1:0] num,
	input  logic [skpl_pkg::DIV_DEN_W-1:0] den,
	output logic done,
	output logic [skpl_pkg::DIV_Q_W-1:0] quo
);

	localparam int CNT_W = $clog2(skpl_pkg::DIV_Q_W);

	logic run_q;
	logic done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [skpl_pkg::DIV_NUM_W-1:0] rem_q;
	logic [skpl_pkg::DIV_NUM_W-1:0] dsh_q;
	logic [skpl_pkg::DIV_Q_W-1:0] quo_q;
	logic ge;

	assign ge = (rem_q >= dsh_q);

	// Control: run while quotient bits remain, then flag done.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(skpl_pkg::DIV_Q_W - 1);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: compare against the shifted divisor and subtract.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			dsh_q <= skpl_pkg::DIV_NUM_W'(den) << (skpl_pkg::DIV_Q_W - 1);
			quo_q <= '0;
		end else if (run_q) begin
			if (ge) begin
				rem_q <= rem_q - dsh_q;
			end
			quo_q <= {quo_q[skpl_pkg::DIV_Q_W-2:0], ge};
			dsh_q <= dsh_q >> 1;
		end
	end

	assign done = done_q;
	assign quo = quo_q;

endmodule

[src/soft_knee_peak_limiter.sv]
// Top level of the soft-knee peak limiter: sequencer, state and datapath.
//
// Input beats on in_ch carry one sample, a sidechain sample, the detector
// select and a channel number; each yields exactly one result beat on out_ch
// with the limited sample, the smoothed gain in 1/256 dB and the busy flag.
// Registers are written through cfg_we / cfg_index / cfg_data; the user
// must write them only while idle, which the block itself does not enforce.
// The block works on one beat at a time: in_ch.ready is high only in idle.
// The work is done on the single shared multiplier: 16 squarings for the
// log, 16 products for the exponential, plus the knee divider.
// The result sits in an output register; if the receiver stalls, the block
// holds it and waits before going back to idle, so no beat is lost.
// Reset clears all smoothers to 0 dB, all hold counters to zero and loads
// the register defaults; no clearing pass is needed.
`include "soft_knee_peak_limiter_macros.svh"

module soft_knee_peak_limiter (
	input  logic clk,
	input  logic arst_n,
	skpl_in_if.sink in_ch,
	skpl_out_if.source out_ch,
	input  logic cfg_we,
	input  logic [skpl_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [skpl_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int CH_W = skpl_pkg::CH_W;
	localparam int MW = skpl_pkg::MUL_W;

	// Configuration registers.
	logic signed [15:0] thr_q;
	logic [12:0] knee_q;
	logic [15:0] atk_q;
	logic [15:0] rel_q;
	logic shared_q;
	logic [19:0] hold_cfg_q;
	logic [22:0] act_q;

	// Channel state.
	logic signed [23:0] sg_q [skpl_pkg::CHANNELS];
	logic [19:0] hold_q [skpl_pkg::CHANNELS];

	// Sequencer and working registers.
	skpl_pkg::skpl_state_t state_q, state_d;
	logic [4:0] cnt_q;
	logic signed [23:0] x_q;
	logic [CH_W-1:0] ch_q;
	logic [CH_W-1:0] sch_q;
	logic [30:0] mm_q;
	logic [4:0] e_q;
	logic [15:0] frac_q;
	logic [14:0] d_q;
	logic signed [15:0] tgt_q;
	logic [16:0] a_q;
	logic signed [skpl_pkg::PROD_W-1:0] acc_q;
	logic signed [23:0] g_q;
	logic [15:0] r_q;
	logic [4:0] q_q;
	logic [30:0] lin_q;

	// Output register.
	logic out_valid_q;
	logic signed [23:0] out_sample_q;
	logic signed [15:0] gain_db_q;
	logic active_q;

	// Shared units.
	logic signed [MW-1:0] mul_a, mul_b;
	logic signed [skpl_pkg::PROD_W-1:0] prod;
	logic div_start, div_done;
	logic [skpl_pkg::DIV_NUM_W-1:0] div_num;
	logic [skpl_pkg::DIV_Q_W-1:0] div_quo;

	skpl_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(prod));

	skpl_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num),
		.den({knee_q, 3'b000}), .done(div_done), .quo(div_quo)
	);

	logic accept, out_free;
	assign accept = in_ch.valid && in_ch.ready;
	assign out_free = !out_valid_q || out_ch.ready;

	// Detector magnitude, its leading-one position and the normalized mantissa.
	logic signed [23:0] det;
	logic [23:0] mabs;
	logic [4:0] e_c;
	logic [30:0] mm0;
	assign det = in_ch.use_sidechain ? in_ch.sidechain_sample : in_ch.in_sample;
	assign mabs = det[23] ? 24'(-det) : 24'(det);

	always_comb begin
		e_c = '0;
		for (int i = 0; i < 24; i++) begin
			if (mabs[i]) begin
				e_c = 5'(i);
			end
		end
	end

	assign mm0 = 31'(55'(mabs) << (5'd30 - e_c));

	// Log squaring step: renormalize the previous square and take its bit.
	logic [31:0] sq_t;
	logic sq_bit;
	logic [30:0] mm_nx, log_src;
	assign sq_t = prod[61:30];
	assign sq_bit = sq_t[31];
	assign mm_nx = sq_bit ? sq_t[31:1] : sq_t[30:0];
	assign log_src = (cnt_q == '0) ? mm_q : mm_nx;

	// Negative log2 of the level in Q16.
	logic [20:0] neg;
	assign neg = (21'(5'd23 - e_q) << 16) - 21'(frac_q);

	// Level in 1/256 dB and the knee curve.
	logic [16:0] lvl_mag;
	logic signed [19:0] lvl_w, thr_w, kw, l2, tt2, tl;
	logic signed [15:0] knee_tgt;
	logic knee_div;
	logic [14:0] d_c;
	assign lvl_mag = 17'(prod[40:24]) + 17'(prod[23]);
	assign lvl_w = -$signed(20'(lvl_mag));
	assign thr_w = 20'(thr_q);
	assign kw = $signed(20'(knee_q));
	assign l2 = lvl_w + lvl_w;
	assign tt2 = thr_w + thr_w;
	assign tl = thr_w - lvl_w;
	assign d_c = 15'(l2 - tt2 + kw);

	always_comb begin
		knee_div = 1'b0;
		knee_tgt = 16'sd0;
		if (knee_q == '0) begin
			knee_tgt = (lvl_w <= thr_w) ? 16'sd0 : skpl_pkg::gain_clamp(tl);
		end else if (l2 < tt2 - kw) begin
			knee_tgt = 16'sd0;
		end else if (l2 <= tt2 + kw) begin
			knee_div = 1'b1;
		end else begin
			knee_tgt = skpl_pkg::gain_clamp(tl);
		end
	end

	assign div_num = 29'(prod[27:0]) + 29'({knee_q, 2'b00});

	logic signed [19:0] quo_w;
	assign quo_w = $signed(20'(div_quo));

	// Smoother operands.
	logic signed [23:0] prev, tgt256;
	logic [16:0] a_sel;
	assign prev = sg_q[sch_q];
	assign tgt256 = $signed({tgt_q, 8'h00});
	assign a_sel = (tgt256 <= prev) ? {1'b0, atk_q} : {1'b0, rel_q};

	logic signed [skpl_pkg::PROD_W-1:0] sm_sum;
	logic signed [23:0] g_c;
	assign sm_sum = acc_q + prod;
	assign g_c = 24'(sm_sum[39:16]) + 24'(sm_sum[15]);

	logic [22:0] ns;
	assign ns = 23'(-g_q);

	// dB to linear: Q16 log2 count, then a product of root factors.
	logic [20:0] n_c;
	logic [30:0] y_src, factor;
	assign n_c = 21'(prod[40:20]) + 21'(prod[19]);
	assign y_src = (cnt_q == '0) ? skpl_pkg::ONE_Q30 : 31'(prod[60:30]) + 31'(prod[29]);
	assign factor = r_q[~cnt_q[3:0]] ? skpl_pkg::ROOT_TBL[cnt_q[3:0]] : skpl_pkg::ONE_Q30;

	// Gain applied to the sample, activity detection and hold counters.
	logic [23:0] ax;
	logic [24:0] mag;
	logic signed [25:0] ys, ysat, diff, adiff;
	logic [19:0] hold_new;
	logic busy;
	assign ax = x_q[23] ? 24'(-x_q) : 24'(x_q);
	assign mag = 25'(prod[54:30]) + 25'(prod[29]);
	assign ys = x_q[23] ? -$signed(26'(mag)) : $signed(26'(mag));
	assign ysat = (ys > 26'sd8388607) ? 26'sd8388607 : ys;
	assign diff = 26'(x_q) - ysat;
	assign adiff = diff[25] ? -diff : diff;

	always_comb begin
		if (adiff > $signed(26'(act_q))) begin
			hold_new = hold_cfg_q;
		end else if (hold_q[ch_q] != '0) begin
			hold_new = hold_q[ch_q] - 1'b1;
		end else begin
			hold_new = '0;
		end
		busy = 1'b0;
		for (int i = 0; i < skpl_pkg::CHANNELS; i++) begin
			if (CH_W'(i) == ch_q) begin
				busy = busy | (hold_new != '0);
			end else begin
				busy = busy | (hold_q[i] != '0);
			end
		end
	end

	// Next state, multiplier operands and unit controls.
	always_comb begin
		state_d = state_q;
		mul_a = '0;
		mul_b = '0;
		div_start = 1'b0;
		case (state_q)
			skpl_pkg::S_IDLE: begin
				if (accept) begin
					state_d = (mabs == '0) ? skpl_pkg::S_SM1 : skpl_pkg::S_LOG;
				end
			end
			skpl_pkg::S_LOG: begin
				mul_a = MW'(log_src);
				mul_b = MW'(log_src);
				if (cnt_q == 5'd16) begin
					state_d = skpl_pkg::S_LVL;
				end
			end
			skpl_pkg::S_LVL: begin
				mul_a = MW'(neg);
				mul_b = skpl_pkg::K_DB_PER_LOG2;
				state_d = skpl_pkg::S_LVL2;
			end
			skpl_pkg::S_LVL2: begin
				state_d = knee_div ? skpl_pkg::S_KSQ : skpl_pkg::S_SM1;
			end
			skpl_pkg::S_KSQ: begin
				mul_a = MW'(d_q);
				mul_b = MW'(d_q);
				state_d = skpl_pkg::S_KDIV0;
			end
			skpl_pkg::S_KDIV0: begin
				div_start = 1'b1;
				state_d = skpl_pkg::S_KDIV;
			end
			skpl_pkg::S_KDIV: begin
				if (div_done) begin
					state_d = skpl_pkg::S_SM1;
				end
			end
			skpl_pkg::S_SM1: begin
				mul_a = MW'(a_sel);
				mul_b = MW'(prev);
				state_d = skpl_pkg::S_SM2;
			end
			skpl_pkg::S_SM2: begin
				mul_a = MW'(17'h10000 - a_q);
				mul_b = MW'(tgt256);
				state_d = skpl_pkg::S_SM3;
			end
			skpl_pkg::S_SM3: begin
				state_d = skpl_pkg::S_NS;
			end
			skpl_pkg::S_NS: begin
				mul_a = MW'(ns);
				mul_b = skpl_pkg::K_LOG2_PER_DB;
				state_d = skpl_pkg::S_N;
			end
			skpl_pkg::S_N: begin
				state_d = skpl_pkg::S_LIN;
			end
			skpl_pkg::S_LIN: begin
				mul_a = MW'(y_src);
				mul_b = MW'(factor);
				if (cnt_q == 5'd16) begin
					state_d = skpl_pkg::S_APP;
				end
			end
			skpl_pkg::S_APP: begin
				mul_a = MW'(ax);
				mul_b = MW'(lin_q);
				state_d = skpl_pkg::S_OUT;
			end
			skpl_pkg::S_OUT: begin
				// Keep the product steady while the result waits for a free slot.
				mul_a = MW'(ax);
				mul_b = MW'(lin_q);
				if (out_free) begin
					state_d = skpl_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = skpl_pkg::S_IDLE;
			end
		endcase
	end

	assign in_ch.ready = (state_q == skpl_pkg::S_IDLE);

	// State register and step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= skpl_pkg::S_IDLE;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q != state_d) begin
				cnt_q <= '0;
			end else if (state_q == skpl_pkg::S_LOG || state_q == skpl_pkg::S_LIN) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// Configuration writes; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= skpl_pkg::THR_RST;
			knee_q <= skpl_pkg::KNEE_RST;
			atk_q <= skpl_pkg::ATK_RST;
			rel_q <= skpl_pkg::REL_RST;
			shared_q <= 1'b0;
			hold_cfg_q <= skpl_pkg::HOLD_RST;
			act_q <= skpl_pkg::ACT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				skpl_pkg::REG_THRESHOLD: thr_q <= cfg_data[15:0];
				skpl_pkg::REG_KNEE: knee_q <= cfg_data[12:0];
				skpl_pkg::REG_ATTACK: atk_q <= cfg_data[15:0];
				skpl_pkg::REG_RELEASE: rel_q <= cfg_data[15:0];
				skpl_pkg::REG_SHARED: shared_q <= cfg_data[0];
				skpl_pkg::REG_HOLD: hold_cfg_q <= cfg_data[19:0];
				skpl_pkg::REG_ACT: act_q <= cfg_data[22:0];
				default: begin
				end
			endcase
		end
	end

	// Per-channel smoother and hold counter state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < skpl_pkg::CHANNELS; i++) begin
				sg_q[i] <= '0;
				hold_q[i] <= '0;
			end
		end else begin
			if (state_q == skpl_pkg::S_SM3) begin
				sg_q[sch_q] <= g_c;
			end
			if (state_q == skpl_pkg::S_OUT && out_free) begin
				hold_q[ch_q] <= hold_new;
			end
		end
	end

	// Working registers, loaded step by step.
	always_ff @(posedge clk) begin
		case (state_q)
			skpl_pkg::S_IDLE: begin
				if (accept) begin
					x_q <= in_ch.in_sample;
					ch_q <= CH_W'(in_ch.channel % skpl_pkg::CHANNELS);
					sch_q <= shared_q ? '0 : CH_W'(in_ch.channel % skpl_pkg::CHANNELS);
					mm_q <= mm0;
					e_q <= e_c;
					tgt_q <= 16'sd0;
				end
			end
			skpl_pkg::S_LOG: begin
				if (cnt_q != '0) begin
					frac_q <= {frac_q[14:0], sq_bit};
				end
			end
			skpl_pkg::S_LVL2: begin
				tgt_q <= knee_tgt;
				d_q <= d_c;
			end
			skpl_pkg::S_KDIV: begin
				if (div_done) begin
					tgt_q <= skpl_pkg::gain_clamp(-quo_w);
				end
			end
			skpl_pkg::S_SM1: begin
				a_q <= a_sel;
			end
			skpl_pkg::S_SM2: begin
				acc_q <= prod;
			end
			skpl_pkg::S_SM3: begin
				g_q <= g_c;
			end
			skpl_pkg::S_N: begin
				q_q <= n_c[20:16];
				r_q <= n_c[15:0];
			end
			skpl_pkg::S_LIN: begin
				if (cnt_q == 5'd16) begin
					lin_q <= (q_q >= 5'd31) ? '0 : (y_src >> q_q);
				end
			end
			default: begin
			end
		endcase
	end

	// Output register: loaded when the result is ready and the slot is free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == skpl_pkg::S_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == skpl_pkg::S_OUT && out_free) begin
			out_sample_q <= ysat[23:0];
			gain_db_q <= 16'(g_q[23:8]) + 16'(g_q[7]);
			active_q <= busy;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.out_sample = out_sample_q;
	assign out_ch.gain_db = gain_db_q;
	assign out_ch.limiter_active = active_q;

	// Checks on the sequencer and the arithmetic.
	`SKPL_ASSERT_NXT(a_one_beat, clk, arst_n, accept, !in_ch.ready, "second beat taken while busy")
	`SKPL_ASSERT_IMP(a_div_owner, clk, arst_n, div_done, state_q == skpl_pkg::S_KDIV, "stray divider result")
	`SKPL_ASSERT_NXT(a_gain_range, clk, arst_n, state_q == skpl_pkg::S_SM3, (g_q <= 24'sd0) && (g_q >= -24'sd6291456), "smoothed gain out of range")
	`SKPL_ASSERT_IMP(a_lin_range, clk, arst_n, state_q == skpl_pkg::S_APP, lin_q <= skpl_pkg::ONE_Q30, "linear gain above unity")

endmodule

[tb/testbench.sv]
// Self-checking testbench of the soft-knee peak limiter with bit-true gain prediction.
`timescale 1ns / 100ps

module testbench;

	localparam logic [skpl_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	typedef struct {
		logic signed [23:0] sample;
		logic signed [23:0] side;
		logic use_side;
		logic [2:0] chan;
	} sample_beat_t;

	typedef struct {
		logic signed [23:0] out_sample;
		logic signed [15:0] gain_db;
		logic active;
	} limited_beat_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [skpl_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [skpl_pkg::CFG_DATA_W-1:0] cfg_data;

	skpl_in_if in_ch();
	skpl_out_if out_ch();

	soft_knee_peak_limiter dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Register copies and per-channel state of the gain predictor.
	longint thr_db;
	longint knee_db;
	longint atk_alpha;
	longint rel_alpha;
	bit shared_mode;
	longint hold_reload;
	longint act_limit;
	longint gain_state [skpl_pkg::CHANNELS];
	longint hold_left [skpl_pkg::CHANNELS];

	sample_beat_t pending_beats[$];
	limited_beat_t expected_results[$];
	sample_beat_t driven_beat;
	int errors;
	int accepted;

	// Integer square root, digit by digit.
	function automatic longint unsigned int_sqrt(input longint unsigned v_in);
		longint unsigned v;
		longint unsigned r;
		longint unsigned b;
		v = v_in;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// Detector magnitude to level in 1/256 dB.
	function automatic longint level_of(input longint unsigned m);
		int e;
		longint unsigned mm;
		longint unsigned frac;
		longint unsigned neg;
		e = 0;
		frac = 0;
		while (e < 23 && (m >> (e + 1)) != 0) e++;
		mm = m << (30 - e);
		for (int k = 0; k < 16; k++) begin
			mm = (mm * mm) >> 30;
			if (mm >= (64'd1 << 31)) begin
				frac = frac | (64'd1 << (15 - k));
				mm = mm >> 1;
			end
		end
		neg = (longint'(23 - e) << 16) - frac;
		return -longint'((neg * 394566 + (64'd1 << 23)) >> 24);
	endfunction

	// Static curve: infinite ratio with a soft or hard knee.
	function automatic longint knee_target(input longint lvl);
		longint g;
		longint d;
		if (knee_db == 0) begin
			g = (lvl <= thr_db) ? 0 : thr_db - lvl;
		end else if (2 * lvl < 2 * thr_db - knee_db) begin
			g = 0;
		end else if (2 * lvl <= 2 * thr_db + knee_db) begin
			d = 2 * lvl - 2 * thr_db + knee_db;
			g = -((d * d + 4 * knee_db) / (8 * knee_db));
		end else begin
			g = thr_db - lvl;
		end
		if (g > 0) g = 0;
		if (g < -24576) g = -24576;
		return g;
	endfunction

	// Gain in 1/65536 dB to a linear factor in Q30.
	function automatic longint unsigned gain_to_linear(input longint g);
		longint unsigned ns;
		longint unsigned n;
		longint unsigned q;
		longint unsigned y;
		longint unsigned f;
		ns = (g < 0) ? longint'(-g) : 0;
		n = (ns * 174165 + (64'd1 << 19)) >> 20;
		q = n >> 16;
		y = 64'd1 << 30;
		f = int_sqrt(64'd1 << 59);
		for (int k = 1; k <= 16; k++) begin
			if ((n >> (16 - k)) & 1) y = (y * f + (64'd1 << 29)) >> 30;
			f = int_sqrt(f << 30);
		end
		return (q >= 31) ? 0 : (y >> q);
	endfunction

	// Works out the result of one accepted beat and advances the state.
	function automatic limited_beat_t limit_beat(input sample_beat_t b);
		limited_beat_t r;
		longint x;
		longint det;
		longint unsigned m;
		longint target;
		longint prev;
		longint alpha;
		longint s;
		longint unsigned lin;
		longint unsigned ax;
		longint unsigned mag;
		longint y;
		longint diff;
		int ch;
		int sch;
		bit busy;
		x = b.sample;
		det = b.use_side ? longint'(b.side) : x;
		ch = b.chan % skpl_pkg::CHANNELS;
		sch = shared_mode ? 0 : ch;
		m = (det < 0) ? -det : det;
		target = (m == 0) ? 0 : knee_target(level_of(m));
		prev = gain_state[sch];
		alpha = (target * 256 <= prev) ? atk_alpha : rel_alpha;
		s = alpha * prev + (65536 - alpha) * (target * 256);
		gain_state[sch] = (s + 32768) >>> 16;
		lin = gain_to_linear(gain_state[sch]);
		ax = (x < 0) ? -x : x;
		mag = (ax * lin + (64'd1 << 29)) >> 30;
		y = (x < 0) ? -longint'(mag) : longint'(mag);
		if (y > 8388607) y = 8388607;
		if (y < -8388608) y = -8388608;
		diff = x - y;
		if (diff < 0) diff = -diff;
		if (diff > act_limit) hold_left[ch] = hold_reload;
		else if (hold_left[ch] > 0) hold_left[ch]--;
		busy = 0;
		for (int i = 0; i < skpl_pkg::CHANNELS; i++) if (hold_left[i] != 0) busy = 1;
		r.out_sample = y[23:0];
		r.gain_db = 16'((gain_state[sch] + 128) >>> 8);
		r.active = busy;
		return r;
	endfunction

	// Clock.
	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Input driver: presents queued beats, with random gaps outside the quiet stretch.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				expected_results.push_back(limit_beat(driven_beat));
				accepted++;
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (pending_beats.size() > 0 &&
					((accepted > 300 && accepted < 420) || $urandom_range(99) >= 20)) begin
					driven_beat = pending_beats.pop_front();
					in_ch.valid <= 1'b1;
					in_ch.in_sample <= driven_beat.sample;
					in_ch.sidechain_sample <= driven_beat.side;
					in_ch.use_sidechain <= driven_beat.use_side;
					in_ch.channel <= driven_beat.chan;
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: random stalls, field checks against the oldest expectation.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (expected_results.size() == 0) begin
					$error("result beat with no expectation waiting");
					errors++;
				end else begin
					limited_beat_t e;
					e = expected_results.pop_front();
					if (out_ch.out_sample !== e.out_sample) begin
						$error("out_sample: expected %0d, actual %0d", e.out_sample,
							out_ch.out_sample);
						errors++;
					end
					if (out_ch.gain_db !== e.gain_db) begin
						$error("gain_db: expected %0d, actual %0d", e.gain_db, out_ch.gain_db);
						errors++;
					end
					if (out_ch.limiter_active !== e.active) begin
						$error("limiter_active: expected %0d, actual %0d", e.active,
							out_ch.limiter_active);
						errors++;
					end
				end
			end
			out_ch.ready <= (accepted > 300 && accepted < 420) || $urandom_range(99) >= 20;
		end
	end

	// Writes one register of the block and of the predictor.
	task automatic write_reg(input logic [skpl_pkg::CFG_IDX_W-1:0] idx, input longint value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[skpl_pkg::CFG_DATA_W-1:0];
		case (idx)
			skpl_pkg::REG_THRESHOLD: thr_db = longint'($signed(value[15:0]));
			skpl_pkg::REG_KNEE: knee_db = value & 64'h1FFF;
			skpl_pkg::REG_ATTACK: atk_alpha = value & 64'hFFFF;
			skpl_pkg::REG_RELEASE: rel_alpha = value & 64'hFFFF;
			skpl_pkg::REG_SHARED: shared_mode = value[0];
			skpl_pkg::REG_HOLD: hold_reload = value & 64'hFFFFF;
			skpl_pkg::REG_ACT: act_limit = value & 64'h7FFFFF;
			default: ;
		endcase
	endtask

	task automatic write_all(input longint t, input longint w, input longint a,
		input longint r, input longint sh, input longint h, input longint act);
		write_reg(skpl_pkg::REG_THRESHOLD, t);
		write_reg(skpl_pkg::REG_KNEE, w);
		write_reg(skpl_pkg::REG_ATTACK, a);
		write_reg(skpl_pkg::REG_RELEASE, r);
		write_reg(skpl_pkg::REG_SHARED, sh);
		write_reg(skpl_pkg::REG_HOLD, h);
		write_reg(skpl_pkg::REG_ACT, act);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Waits until every beat is through and the block has settled.
	task automatic drain();
		while (pending_beats.size() > 0 || in_ch.valid || expected_results.size() > 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	function automatic sample_beat_t make_beat(input logic signed [23:0] s,
		input logic signed [23:0] sc, input logic us, input logic [2:0] c);
		sample_beat_t b;
		b.sample = s;
		b.side = sc;
		b.use_side = us;
		b.chan = c;
		return b;
	endfunction

	// Random level spread over the whole dB range: a random word shifted down.
	function automatic logic signed [23:0] rand_level(input int shift);
		logic signed [31:0] raw;
		raw = $urandom;
		return 24'(raw >>> (8 + shift));
	endfunction

	// Bursts of loud and quiet passages per channel, with some stray beats.
	task automatic queue_random(input int count);
		int loud;
		logic [2:0] c;
		loud = 0;
		c = 0;
		for (int i = 0; i < count; i++) begin
			if (i % 10 == 0) begin
				loud = $urandom_range(23);
				c = 3'($urandom);
			end
			if ($urandom_range(9) == 0)
				pending_beats.push_back(make_beat(24'($urandom), 24'($urandom),
					1'($urandom), 3'($urandom)));
			else
				pending_beats.push_back(make_beat(rand_level(loud), rand_level($urandom_range(23)),
					$urandom_range(3) == 0, ($urandom_range(3) == 0) ? 3'($urandom) : c));
		end
	endtask

	initial begin
		errors = 0;
		accepted = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.in_sample = '0;
		in_ch.sidechain_sample = '0;
		in_ch.use_sidechain = 1'b0;
		in_ch.channel = '0;
		out_ch.ready = 1'b0;
		thr_db = -256;
		knee_db = 1536;
		atk_alpha = 62604;
		rel_alpha = 65505;
		shared_mode = 0;
		hold_reload = 4800;
		act_limit = 16;
		for (int i = 0; i < skpl_pkg::CHANNELS; i++) begin
			gain_state[i] = 0;
			hold_left[i] = 0;
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed beats at reset settings: extremes, zero level, sidechain, all channels.
		pending_beats.push_back(make_beat(24'sh7FFFFF, 0, 0, 0));
		pending_beats.push_back(make_beat(-24'sh800000, 0, 0, 1));
		pending_beats.push_back(make_beat(0, 0, 0, 2));
		pending_beats.push_back(make_beat(24'sh7FFFFF, 0, 1, 3));
		pending_beats.push_back(make_beat(1, -24'sh800000, 1, 4));
		pending_beats.push_back(make_beat(-1, 24'sh7FFFFF, 1, 5));
		pending_beats.push_back(make_beat(24'sh700000, 1, 1, 6));
		pending_beats.push_back(make_beat(-24'sh7FFFFF, -1, 0, 7));
		pending_beats.push_back(make_beat(24'sh7A0000, 0, 0, 7));
		pending_beats.push_back(make_beat(24'sh720000, 0, 0, 7));
		pending_beats.push_back(make_beat(24'sh400000, 0, 0, 0));
		pending_beats.push_back(make_beat(24'sh000100, 0, 0, 0));
		drain();

		// Hard knee, instant smoothing, shared smoother, no hold, zero activity limit.
		write_all(0, 0, 0, 0, 1, 0, 0);
		write_reg(REG_UNUSED, 23'h7FFFFF);
		@(posedge clk);
		cfg_we <= 1'b0;
		pending_beats.push_back(make_beat(24'sh7FFFFF, 0, 0, 3));
		pending_beats.push_back(make_beat(-24'sh800000, 0, 0, 5));
		pending_beats.push_back(make_beat(24'sh123456, 0, 1, 6));
		pending_beats.push_back(make_beat(1, 0, 0, 2));
		pending_beats.push_back(make_beat(-24'sh400000, 24'sh200000, 1, 1));
		drain();

		// Threshold -24576 and knee 6144 (1/256 dB), slowest smoothing, longest hold, largest limit.
		write_all(-24576, 6144, 65535, 65535, 0, 1048575, 8388607);
		pending_beats.push_back(make_beat(24'sh7FFFFF, 0, 0, 0));
		pending_beats.push_back(make_beat(24'sh000010, 0, 0, 1));
		pending_beats.push_back(make_beat(-24'sh800000, 0, 0, 1));
		queue_random(40);
		drain();

		// Random settings, short holds on every other pass so the busy flag also drops.
		for (int p = 0; p < 5; p++) begin
			write_all(-longint'($urandom_range(24576)),
				($urandom_range(3) == 0) ? 0 : $urandom_range(6144),
				$urandom_range(65535), $urandom_range(65535), $urandom_range(1),
				(p % 2) ? $urandom_range(8) : $urandom_range(1048575),
				$urandom_range(3) == 0 ? $urandom_range(8388607) : $urandom_range(64));
			queue_random(115);
			drain();
		end

		if (errors == 0) begin
			$display("soft_knee_peak_limiter regression: pass");
		end else begin
			$display("soft_knee_peak_limiter regression: fail");
		end
		$finish;
	end

	// Run limit, far beyond the slowest correct run.
	initial begin
		#20ms;
		$display("soft_knee_peak_limiter regression: fail");
		$finish;
	end

endmodule

[soft_knee_peak_limiter.f]
+incdir+src
src/skpl_pkg.sv
src/skpl_if.sv
src/skpl_mul.sv
src/skpl_div.sv
src/soft_knee_peak_limiter.sv
tb/testbench.sv
